// ----- design/stdl_pkg.sv -----
`default_nettype none

package stdl_pkg;

	localparam logic [11:0] FIRST_YEAR = 12'd1900;
	localparam logic [11:0] LAST_YEAR  = 12'd2099;
	localparam logic [11:0] LATE_YEAR  = 12'd2060;
	localparam int          NUM_TERMS  = 24;
	localparam int          FLAG_DEPTH = 201;
	localparam int          FLAG_AW    = $clog2(FLAG_DEPTH);

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} in_item_t;

	typedef struct packed {
		logic       error;
		logic [4:0] term_index;
		logic [4:0] days_left;
		logic [4:0] first_term_day;
		logic [4:0] second_term_day;
		logic [4:0] next_term_day;
	} out_item_t;

	// base days packed as {first, second, next month's first}
	localparam logic [23:0] BASE_EARLY [12] = '{
		24'h061404, 24'h041306, 24'h061505, 24'h051406, 24'h061506, 24'h061507,
		24'h071708, 24'h081708, 24'h081708, 24'h081808, 24'h081607, 24'h071606};

	localparam logic [23:0] BASE_LATE [12] = '{
		24'h051404, 24'h041305, 24'h051405, 24'h051405, 24'h051505, 24'h051507,
		24'h071707, 24'h071707, 24'h071708, 24'h081707, 24'h071607, 24'h071605};

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

	// one entry per year from 1900 to 2100, bit 23-t flags a moved term t
	localparam logic [23:0] SHIFT_FLAGS [FLAG_DEPTH] = '{
		24'h001024, 24'h415966, 24'h637D67, 24'h7FFFE7, 24'hF01024,
		24'h415966, 24'h635D67, 24'h7FFFE7, 24'hF01024, 24'h415966,
		24'h635D67, 24'h7F7FE7, 24'hF01000, 24'h015926, 24'h415D67,
		24'h777DE7, 24'h701000, 24'h011926, 24'h415D66, 24'h777DE7,
		24'h701000, 24'h001924, 24'h415D66, 24'h737DE7, 24'h701000,
		24'h001924, 24'h415966, 24'h637D67, 24'h700018, 24'h001024,
		24'h415966, 24'h637D67, 24'h700018, 24'h001024, 24'h415966,
		24'h635D67, 24'h700018, 24'h001024, 24'h415966, 24'h635D67,
		24'h700018, 24'h001024, 24'h415966, 24'h635D67, 24'h708018,
		24'h001000, 24'h015926, 24'h415D67, 24'h788218, 24'h801000,
		24'h001926, 24'h415D67, 24'h788218, 24'h801000, 24'h001924,
		24'h415966, 24'h7C8218, 24'h801000, 24'h001024, 24'h415966,
		24'h6C8298, 24'h800018, 24'h001024, 24'h415966, 24'h6C8298,
		24'h800018, 24'h001024, 24'h415966, 24'h6CA298, 24'h800018,
		24'h001024, 24'h415966, 24'h6CA298, 24'h808018, 24'h001024,
		24'h415926, 24'h6EA298, 24'h808218, 24'h001004, 24'h411926,
		24'h6EA298, 24'h808218, 24'h001000, 24'h001926, 24'h4EA698,
		24'h888218, 24'h801000, 24'h001124, 24'h4EA699, 24'h8C8298,
		24'h800000, 24'h001024, 24'h4EA699, 24'h9C8298, 24'h800018,
		24'h001024, 24'h4EA699, 24'h9CA298, 24'h800018, 24'h001024,
		24'h4EA699, 24'h9CA298, 24'h800018, 24'h001024, 24'h4EA699,
		24'h9CA298, 24'h808218, 24'h001024, 24'h4EA6D9, 24'h9EA298,
		24'h808218, 24'h001004, 24'h4EE6D9, 24'h9EA698, 24'h808218,
		24'h001000, 24'h0FEED9, 24'hBEA698, 24'h888218, 24'h800000,
		24'h0FEFDB, 24'hBEA699, 24'h8C8298, 24'h800000, 24'h0FEFDB,
		24'hBEA699, 24'h9CA298, 24'h800018, 24'h0FEFDB, 24'hBEA699,
		24'h9CA298, 24'h800018, 24'h0FEFDB, 24'hBEA699, 24'h9CA298,
		24'h808218, 24'h0FEFDB, 24'hBEA6D9, 24'h9CA298, 24'h808218,
		24'h0FEFFB, 24'hBEE6D9, 24'h9EA698, 24'h808218, 24'h0FEFFB,
		24'hBFE6D9, 24'h9EA698, 24'h808218, 24'h0FFFFF, 24'hFFEFD9,
		24'hBEA698, 24'h888298, 24'h8FFFFF, 24'hFFEFD9, 24'hBEA698,
		24'h8CA298, 24'h8FFFFF, 24'hFFEFDB, 24'hBEA699, 24'h9CA298,
		24'h035D7F, 24'h734D43, 24'h320401, 24'h100000, 24'h035D7F,
		24'h734D43, 24'h320401, 24'h100000, 24'h03DF7F, 24'h734D43,
		24'h324441, 24'h100000, 24'h03DF7F, 24'h734D63, 24'h324441,
		24'h120400, 24'h03DF7F, 24'h734D63, 24'h334C41, 24'h120400,
		24'h03DF7F, 24'h735D67, 24'h334D41, 24'h120400, 24'h0BDFFF,
		24'h735D67, 24'h734D41, 24'h320400, 24'h0FFFFF, 24'hF35D67,
		24'h734D43, 24'h320401, 24'h0FFFFF, 24'hF35D7F, 24'h734D43,
		24'h320401, 24'h1FFFFF, 24'hF3DF7F, 24'h734D43, 24'h320401,
		24'h100000};

	// 1 when flagged term t of year yr moves back a day, 0 when it moves forward
	function automatic logic move_back(input logic [11:0] yr, input logic [4:0] t);
		logic fwd;
		if (yr > 12'd2015) begin
			return 1'b1;
		end
		if (yr < 12'd1944) begin
			return (t == 5'd19) || (t == 5'd20);
		end
		fwd = (t == 5'd1) || (t == 5'd2) || (t == 5'd7) || (t == 5'd11) ||
		      (t == 5'd12) || (t == 5'd15) || (t == 5'd18) || (t == 5'd21) ||
		      (t == 5'd22) ||
		      ((t == 5'd3) && (yr < 12'd1993)) || ((t == 5'd9) && (yr < 12'd2012)) ||
		      ((t == 5'd13) && (yr < 12'd1984)) || ((t == 5'd17) && (yr < 12'd2008)) ||
		      ((t == 5'd23) && (yr < 12'd1988));
		return !fwd;
	endfunction

	function automatic logic [4:0] move_day(input logic [4:0] d, input logic flag,
	                                        input logic back);
		if (!flag) begin
			return d;
		end
		return back ? d - 5'd1 : d + 5'd1;
	endfunction

endpackage

`default_nettype wire

// ----- design/solar_term_date_lookup.sv -----
`default_nettype none

// Channel | Direction | Handshake          | Item
// in      | input     | in_valid/in_ready  | stdl_pkg::in_item_t  (year, month, day)
// out     | output    | out_valid/out_ready| stdl_pkg::out_item_t (error, terms, days)
//
// One item per cycle sustained while out_ready is high; an accepted item goes
// to the entry register, then to the result register, where out_valid rises.
// The item is registered on entry, then one pass of table lookups and compares
// fills the result register.
// Reset clears the two valid flags only.
// A stalled result holds in place; the entry register takes an item when it is
// empty or when the result register can move on.

module solar_term_date_lookup (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  stdl_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output stdl_pkg::out_item_t out_data
);

	logic                valid_s1;
	stdl_pkg::in_item_t  item_s1;
	logic                out_adv;
	logic                s1_adv;
	stdl_pkg::out_item_t res;

	logic                year_ok;
	logic                month_ok;
	logic                leap;
	logic [3:0]          mi;
	logic [4:0]          mdays;
	logic [11:0]         yoff;
	logic [stdl_pkg::FLAG_AW-1:0] fidx;
	logic [stdl_pkg::FLAG_AW-1:0] fidx_n;
	logic [23:0]         base;
	logic [23:0]         fl;
	logic [23:0]         fl_n;
	logic                dec;
	logic [11:0]         yr_n;
	logic [4:0]          t0;
	logic [4:0]          t1;
	logic [4:0]          tn;
	logic [4:0]          d0;
	logic [4:0]          d1;
	logic [4:0]          d2;
	logic [4:0]          b2;
	logic [5:0]          left_next;

	assign out_adv  = !out_valid || out_ready;
	assign s1_adv   = !valid_s1 || out_adv;
	assign in_ready = s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_comb begin
		year_ok  = (item_s1.year >= stdl_pkg::FIRST_YEAR) && (item_s1.year <= stdl_pkg::LAST_YEAR);
		month_ok = (item_s1.month >= 4'd1) && (item_s1.month <= 4'd12);
		mi       = month_ok ? item_s1.month - 4'd1 : 4'd0;
		// only 1900 and 2000 are century years in range, and only 2000 is leap
		leap     = (item_s1.year[1:0] == 2'b00) && (item_s1.year != stdl_pkg::FIRST_YEAR);
		mdays    = stdl_pkg::MONTH_LEN[mi] + 5'((mi == 4'd1) && leap);

		yoff   = year_ok ? item_s1.year - stdl_pkg::FIRST_YEAR : 12'd0;
		fidx   = yoff[stdl_pkg::FLAG_AW-1:0];
		dec    = (item_s1.month == 4'd12);
		fidx_n = dec ? fidx + stdl_pkg::FLAG_AW'(1) : fidx;
		yr_n   = dec ? item_s1.year + 12'd1 : item_s1.year;
		fl     = stdl_pkg::SHIFT_FLAGS[fidx];
		fl_n   = stdl_pkg::SHIFT_FLAGS[fidx_n];

		base = (item_s1.year < stdl_pkg::LATE_YEAR) ? stdl_pkg::BASE_EARLY[mi]
		                                             : stdl_pkg::BASE_LATE[mi];
		t0 = {mi, 1'b0};
		t1 = {mi, 1'b1};
		tn = dec ? 5'd0 : {item_s1.month, 1'b0};

		b2 = base[4:0];
		if (dec && (item_s1.year == 12'd2059)) begin
			b2 = b2 - 5'd1;
		end
		d0 = stdl_pkg::move_day(base[20:16], fl[5'd23 - t0],
		                        stdl_pkg::move_back(item_s1.year, t0));
		d1 = stdl_pkg::move_day(base[12:8], fl[5'd23 - t1],
		                        stdl_pkg::move_back(item_s1.year, t1));
		d2 = stdl_pkg::move_day(b2, fl_n[5'd23 - tn], stdl_pkg::move_back(yr_n, tn));

		left_next = {1'b0, mdays} - {1'b0, item_s1.day} + {1'b0, d2};

		res = '0;
		if (!year_ok || !month_ok || (item_s1.day == 5'd0) || (item_s1.day > mdays)) begin
			res.error = 1'b1;
		end else begin
			res.first_term_day  = d0;
			res.second_term_day = d1;
			res.next_term_day   = d2;
			if (item_s1.day <= d0) begin
				res.term_index = t0;
				res.days_left  = d0 - item_s1.day;
			end else if (item_s1.day <= d1) begin
				res.term_index = t1;
				res.days_left  = d1 - item_s1.day;
			end else begin
				res.term_index = tn;
				res.days_left  = left_next[4:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			out_data <= res;
		end
	end

	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error |-> out_data.term_index == 5'd0 &&
		out_data.days_left == 5'd0 && out_data.first_term_day == 5'd0 &&
		out_data.second_term_day == 5'd0 && out_data.next_term_day == 5'd0)
		else $error("error result carries nonzero fields");

	a_terms_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.error |->
		out_data.term_index <= 5'd23 && out_data.first_term_day < out_data.second_term_day)
		else $error("term index or term days out of order");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |-> !in_ready)
		else $error("item taken while both stages are held");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_adv |=> out_valid)
		else $error("item lost between entry and result registers");

endmodule

`default_nettype wire

// ----- verif/solar_term_date_lookup_tb.sv -----
`timescale 1ns / 100ps

// Local copies of the term tables, kept apart from the design package
localparam logic [23:0] TERM_BASE_PRE2060 [12] = '{
	24'h061404, 24'h041306, 24'h061505, 24'h051406, 24'h061506, 24'h061507,
	24'h071708, 24'h081708, 24'h081708, 24'h081808, 24'h081607, 24'h071606};

localparam logic [23:0] TERM_BASE_FROM2060 [12] = '{
	24'h051404, 24'h041305, 24'h051405, 24'h051405, 24'h051505, 24'h051507,
	24'h071707, 24'h071707, 24'h071708, 24'h081707, 24'h071607, 24'h071605};

localparam int CAL_MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

// 1900..2100, bit 23-t set when term t is a day off its base
localparam logic [23:0] TERM_MOVE_FLAGS [201] = '{
	24'h001024, 24'h415966, 24'h637D67, 24'h7FFFE7, 24'hF01024, 24'h415966, 24'h635D67,
	24'h7FFFE7, 24'hF01024, 24'h415966, 24'h635D67, 24'h7F7FE7, 24'hF01000, 24'h015926,
	24'h415D67, 24'h777DE7, 24'h701000, 24'h011926, 24'h415D66, 24'h777DE7, 24'h701000,
	24'h001924, 24'h415D66, 24'h737DE7, 24'h701000, 24'h001924, 24'h415966, 24'h637D67,
	24'h700018, 24'h001024, 24'h415966, 24'h637D67, 24'h700018, 24'h001024, 24'h415966,
	24'h635D67, 24'h700018, 24'h001024, 24'h415966, 24'h635D67, 24'h700018, 24'h001024,
	24'h415966, 24'h635D67, 24'h708018, 24'h001000, 24'h015926, 24'h415D67, 24'h788218,
	24'h801000, 24'h001926, 24'h415D67, 24'h788218, 24'h801000, 24'h001924, 24'h415966,
	24'h7C8218, 24'h801000, 24'h001024, 24'h415966, 24'h6C8298, 24'h800018, 24'h001024,
	24'h415966, 24'h6C8298, 24'h800018, 24'h001024, 24'h415966, 24'h6CA298, 24'h800018,
	24'h001024, 24'h415966, 24'h6CA298, 24'h808018, 24'h001024, 24'h415926, 24'h6EA298,
	24'h808218, 24'h001004, 24'h411926, 24'h6EA298, 24'h808218, 24'h001000, 24'h001926,
	24'h4EA698, 24'h888218, 24'h801000, 24'h001124, 24'h4EA699, 24'h8C8298, 24'h800000,
	24'h001024, 24'h4EA699, 24'h9C8298, 24'h800018, 24'h001024, 24'h4EA699, 24'h9CA298,
	24'h800018, 24'h001024, 24'h4EA699, 24'h9CA298, 24'h800018, 24'h001024, 24'h4EA699,
	24'h9CA298, 24'h808218, 24'h001024, 24'h4EA6D9, 24'h9EA298, 24'h808218, 24'h001004,
	24'h4EE6D9, 24'h9EA698, 24'h808218, 24'h001000, 24'h0FEED9, 24'hBEA698, 24'h888218,
	24'h800000, 24'h0FEFDB, 24'hBEA699, 24'h8C8298, 24'h800000, 24'h0FEFDB, 24'hBEA699,
	24'h9CA298, 24'h800018, 24'h0FEFDB, 24'hBEA699, 24'h9CA298, 24'h800018, 24'h0FEFDB,
	24'hBEA699, 24'h9CA298, 24'h808218, 24'h0FEFDB, 24'hBEA6D9, 24'h9CA298, 24'h808218,
	24'h0FEFFB, 24'hBEE6D9, 24'h9EA698, 24'h808218, 24'h0FEFFB, 24'hBFE6D9, 24'h9EA698,
	24'h808218, 24'h0FFFFF, 24'hFFEFD9, 24'hBEA698, 24'h888298, 24'h8FFFFF, 24'hFFEFD9,
	24'hBEA698, 24'h8CA298, 24'h8FFFFF, 24'hFFEFDB, 24'hBEA699, 24'h9CA298, 24'h035D7F,
	24'h734D43, 24'h320401, 24'h100000, 24'h035D7F, 24'h734D43, 24'h320401, 24'h100000,
	24'h03DF7F, 24'h734D43, 24'h324441, 24'h100000, 24'h03DF7F, 24'h734D63, 24'h324441,
	24'h120400, 24'h03DF7F, 24'h734D63, 24'h334C41, 24'h120400, 24'h03DF7F, 24'h735D67,
	24'h334D41, 24'h120400, 24'h0BDFFF, 24'h735D67, 24'h734D41, 24'h320400, 24'h0FFFFF,
	24'hF35D67, 24'h734D43, 24'h320401, 24'h0FFFFF, 24'hF35D7F, 24'h734D43, 24'h320401,
	24'h1FFFFF, 24'hF3DF7F, 24'h734D43, 24'h320401, 24'h100000};

// 0 for a month out of range; Gregorian leap rule for February
function automatic int days_in_month(input int yr, input int mo);
	if (mo < 1 || mo > 12) begin
		return 0;
	end
	if (mo == 2 && yr % 4 == 0 && (yr % 100 != 0 || yr % 400 == 0)) begin
		return 29;
	end
	return CAL_MONTH_DAYS[mo - 1];
endfunction

// direction of the one-day correction: 1 means earlier, 0 means later
function automatic bit term_moves_back(input int yr, input int t);
	if (yr > 2015) begin
		return 1'b1;
	end
	if (yr < 1944) begin
		return t == 19 || t == 20;
	end
	case (t)
		1, 2, 7, 11, 12, 15, 18, 21, 22: return 1'b0;
		3: return yr >= 1993;
		9: return yr >= 2012;
		13: return yr >= 1984;
		17: return yr >= 2008;
		23: return yr >= 1988;
		default: return 1'b1;
	endcase
endfunction

function automatic stdl_pkg::out_item_t predict_terms(input stdl_pkg::in_item_t d);
	stdl_pkg::out_item_t r;
	int yr, mo, dy, mlen, t0, tn, t, fy, idx, left;
	logic [23:0] base;
	int term_day [3];
	r = '0;
	yr = d.year;
	mo = d.month;
	dy = d.day;
	mlen = (yr < 1900 || yr > 2099) ? 0 : days_in_month(yr, mo);
	if (dy == 0 || dy > mlen) begin
		r.error = 1'b1;
		return r;
	end
	t0 = (mo - 1) * 2;
	tn = (mo * 2) % 24;
	base = (yr < 2060) ? TERM_BASE_PRE2060[mo - 1] : TERM_BASE_FROM2060[mo - 1];
	term_day[0] = base[23:16];
	term_day[1] = base[15:8];
	term_day[2] = base[7:0];
	if (yr == 2059 && mo == 12) begin
		term_day[2]--;
	end
	for (int i = 0; i < 3; i++) begin
		t = (t0 + i) % 24;
		// December looks ahead to January of the next year
		fy = (i == 2 && mo == 12) ? yr + 1 : yr;
		if (TERM_MOVE_FLAGS[fy - 1900][23 - t]) begin
			term_day[i] += term_moves_back(fy, t) ? -1 : 1;
		end
	end
	if (dy <= term_day[0]) begin
		idx = t0;
		left = term_day[0] - dy;
	end else if (dy <= term_day[1]) begin
		idx = t0 + 1;
		left = term_day[1] - dy;
	end else begin
		idx = tn;
		left = mlen - dy + term_day[2];
	end
	r.term_index = 5'(idx);
	r.days_left = 5'(left);
	r.first_term_day = 5'(term_day[0]);
	r.second_term_day = 5'(term_day[1]);
	r.next_term_day = 5'(term_day[2]);
	return r;
endfunction

class term_scoreboard;
	stdl_pkg::out_item_t due[$];
	int mismatches;
	int good_dates;
	int bad_dates;
	int results_seen;

	function void note_date(input stdl_pkg::in_item_t d);
		stdl_pkg::out_item_t e;
		e = predict_terms(d);
		if (e.error) begin
			bad_dates++;
		end else begin
			good_dates++;
		end
		due.push_back(e);
	endfunction

	function void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endfunction

	function void check_result(input stdl_pkg::out_item_t got);
		stdl_pkg::out_item_t e;
		results_seen++;
		if (due.size() == 0) begin
			mismatches++;
			$display("%0t: result with nothing expected, expected none got %h", $time, got);
			return;
		end
		e = due.pop_front();
		compare_field("error", e.error, got.error);
		compare_field("term_index", e.term_index, got.term_index);
		compare_field("days_left", e.days_left, got.days_left);
		compare_field("first_term_day", e.first_term_day, got.first_term_day);
		compare_field("second_term_day", e.second_term_day, got.second_term_day);
		compare_field("next_term_day", e.next_term_day, got.next_term_day);
	endfunction
endclass

module solar_term_date_lookup_tb;

	localparam int RANDOM_DATES = 750;
	localparam int QUIET_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	stdl_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	stdl_pkg::out_item_t out_data;

	term_scoreboard ledger = new;
	int quiet_cycles = 0;

	solar_term_date_lookup uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				ledger.note_date(in_data);
			end
			if (out_valid && out_ready) begin
				ledger.check_result(out_data);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("solar_term_date_lookup_tb: errors");
				$finish;
			end
		end
	end

	// entered just after a falling edge, returns just after one
	task automatic send_date(input stdl_pkg::in_item_t d, input bit calm);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		forever begin
			@(posedge clk);
			if (in_ready) begin
				break;
			end
		end
		@(negedge clk);
	endtask

	// mostly well-formed dates, the rest raw noise across every field bit
	function automatic stdl_pkg::in_item_t random_date();
		stdl_pkg::in_item_t d;
		int yr, mo;
		if ($urandom_range(0, 9) < 2) begin
			d.year = 12'($urandom_range(0, 4095));
			d.month = 4'($urandom_range(0, 15));
			d.day = 5'($urandom_range(0, 31));
		end else begin
			yr = $urandom_range(1900, 2099);
			mo = $urandom_range(1, 12);
			d.year = 12'(yr);
			d.month = 4'(mo);
			d.day = 5'($urandom_range(1, days_in_month(yr, mo)));
		end
		return d;
	endfunction

	initial begin
		bit calm;
		int slot;
		calm = 1'b0;
		slot = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (slot % 50 == 0) begin
				calm = ($urandom_range(0, 2) == 0);
			end
			slot++;
			if (!calm && $urandom_range(0, 8) > 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			out_ready <= 1'b1;
			forever begin
				@(posedge clk);
				if (out_valid) begin
					break;
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		stdl_pkg::in_item_t edge_dates [25];
		bit calm;
		edge_dates = '{
			{12'd1900, 4'd1, 5'd1},
			{12'd2099, 4'd12, 5'd31},
			{12'd1899, 4'd6, 5'd10},
			{12'd2100, 4'd1, 5'd1},
			{12'd4095, 4'd15, 5'd31},
			{12'd0, 4'd0, 5'd0},
			{12'd2000, 4'd13, 5'd5},
			{12'd2000, 4'd2, 5'd29},
			{12'd1900, 4'd2, 5'd29},
			{12'd2001, 4'd2, 5'd29},
			{12'd2004, 4'd4, 5'd31},
			{12'd2020, 4'd3, 5'd0},
			{12'd2059, 4'd12, 5'd31},
			{12'd2059, 4'd12, 5'd1},
			{12'd2060, 4'd1, 5'd3},
			{12'd1943, 4'd10, 5'd8},
			{12'd1944, 4'd10, 5'd23},
			{12'd2015, 4'd12, 5'd22},
			{12'd2016, 4'd6, 5'd21},
			{12'd1992, 4'd2, 5'd4},
			{12'd1993, 4'd2, 5'd19},
			{12'd2011, 4'd5, 5'd5},
			{12'd1983, 4'd7, 5'd7},
			{12'd2007, 4'd9, 5'd8},
			{12'd1987, 4'd12, 5'd22}};
		calm = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (edge_dates[i]) begin
			send_date(edge_dates[i], 1'b0);
		end
		for (int n = 0; n < RANDOM_DATES; n++) begin
			if (n % 40 == 0) begin
				calm = ($urandom_range(0, 2) == 0);
			end
			send_date(random_date(), calm);
		end
		in_valid <= 1'b0;

		while (ledger.due.size() != 0) begin
			@(posedge clk);
		end
		// two-stage pipe: the extra wait below catches any stray result
		repeat (12) @(posedge clk);

		$display("%0d dates in range and %0d rejected, directed edges plus random mix",
			ledger.good_dates, ledger.bad_dates);
		$display("%0d results compared, %0d field mismatches",
			ledger.results_seen, ledger.mismatches);
		if (ledger.mismatches == 0) begin
			$display("solar_term_date_lookup_tb: clean");
		end else begin
			$display("solar_term_date_lookup_tb: errors");
		end
		$finish;
	end

endmodule
